>>> sv/depthwise_causal_conv1d_unit_assert.svh
// Assertion macros for the depthwise causal convolution RTL.
// Depends on nothing; included by depthwise_causal_conv1d_unit, the one module with assertions.
`ifndef DEPTHWISE_CAUSAL_CONV1D_UNIT_ASSERT_SVH
`define DEPTHWISE_CAUSAL_CONV1D_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DCC_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dcc_pkg.sv
// Shared types and constants for the depthwise causal convolution unit.
// Depends on nothing; used by dcc_tap_cell and depthwise_causal_conv1d_unit.
`default_nettype none

package dcc_pkg;

    // Default sizes and the largest tap count the accumulator is sized for.
    localparam int NUM_CHANNELS_DEF = 64;
    localparam int MAX_TAPS_DEF     = 4;
    localparam int MAX_TAPS_LIMIT   = 16;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 6;
    localparam int TAP_W    = 2;
    localparam int REQ_W    = 2;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int OUT_W    = 32;
    localparam int FRAC_W   = 12;

    // Bias term plus up to MAX_TAPS_LIMIT products, each of magnitude at most 2^30.
    localparam int ACC_W = OUT_W + $clog2(MAX_TAPS_LIMIT + 1);

    // Configuration port.
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 4;
    localparam int CIU_W   = 7;
    localparam int TIU_W   = 3;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_TAPS     = 2'd1;
    localparam logic [1:0] REG_TAIL     = 2'd2;

    localparam logic [CIU_W-1:0] CIU_RESET = 7'd64;
    localparam logic [TIU_W-1:0] TIU_RESET = 3'd4;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BIAS    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HISTORY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd3;

    // Partial sum travelling along the row of cells with its sideband.
    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   channel;
        logic [ACC_W-1:0]  psum;
    } t_link;

    // Per-cell control for the item leaving the first stage.
    typedef struct packed {
        logic w_we;
        logic h_we;
        logic h_zero;
        logic active;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> sv/depthwise_causal_conv1d_unit.sv
// Top level of the depthwise causal convolution unit: configuration registers,
// request decode, bias store, clearing pass, row of tap cells and output stage.
// Depends on dcc_pkg, dcc_tap_cell and depthwise_causal_conv1d_unit_assert.svh.
//
// Use: items arrive on the input channel (i_valid / o_stall). Weight, bias and
// history loads give no result; each sample on an active channel gives exactly
// one result on the output channel (o_valid / i_stall), in arrival order. An
// item is transferred at a rising edge where valid is high and stall is low.
// Path: a sample passes one stage for the store reads, one for operand
// selection, one for the multipliers, then one cell of the partial sum chain
// per tap, then the output register, where its result appears on o_valid.
// Throughput: one item per cycle while o_stall is low, loads and samples mixed
// freely, including back-to-back samples on the same channel; bypass registers
// in each store forward the write of the previous item.
// Reset: synchronous, active low. After it the history stores are cleared one
// channel per cycle, through all NUM_CHANNELS channels, with o_stall held high;
// configuration writes are taken throughout. Weights and bias hold no value
// until loaded.
// Stall: a result that is not taken waits in the output register while the
// pipeline keeps moving; a second waiting result fills a skid register, and
// only then does the whole pipeline freeze and o_stall rise.
`default_nettype none

`include "depthwise_causal_conv1d_unit_assert.svh"

module depthwise_causal_conv1d_unit #(
    parameter int NUM_CHANNELS = dcc_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_TAPS     = dcc_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dcc_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [dcc_pkg::APB_DW-1:0]          pwdata,
    output logic [dcc_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready,
    // Input channel.
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [dcc_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic [dcc_pkg::CH_W-1:0]            i_channel,
    input  wire logic [dcc_pkg::TAP_W-1:0]           i_tap,
    input  wire logic signed [dcc_pkg::SAMPLE_W-1:0] i_value,
    input  wire logic                                i_sequence_start,
    // Output channel.
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [dcc_pkg::OUT_W-1:0]         o_filtered_value,
    output logic [dcc_pkg::CH_W-1:0]                 o_out_channel
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int K_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS + 1) : 1;
    localparam logic [CH_AW-1:0] CLR_LAST = CH_AW'(NUM_CHANNELS - 1);
    localparam int SW = dcc_pkg::SAMPLE_W;
    localparam int AW = dcc_pkg::ACC_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; the
    // port never inserts wait states.
    // ------------------------------------------------------------------
    logic [dcc_pkg::CIU_W-1:0] r_channels_in_use;
    logic [dcc_pkg::TIU_W-1:0] r_taps_in_use;
    logic                      r_use_tail;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels_in_use <= dcc_pkg::CIU_RESET;
            r_taps_in_use     <= dcc_pkg::TIU_RESET;
            r_use_tail        <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                dcc_pkg::REG_CHANNELS: r_channels_in_use <= pwdata[dcc_pkg::CIU_W-1:0];
                dcc_pkg::REG_TAPS:     r_taps_in_use     <= pwdata[dcc_pkg::TIU_W-1:0];
                dcc_pkg::REG_TAIL:     r_use_tail        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dcc_pkg::REG_CHANNELS: prdata = dcc_pkg::APB_DW'(r_channels_in_use);
            dcc_pkg::REG_TAPS:     prdata = dcc_pkg::APB_DW'(r_taps_in_use);
            dcc_pkg::REG_TAIL:     prdata = dcc_pkg::APB_DW'(r_use_tail);
            default:               prdata = '0;
        endcase
    end

    // Effective tap count: zero acts as one, anything above MAX_TAPS is clamped.
    logic [K_W-1:0] k_eff;

    always_comb begin
        if (r_taps_in_use == '0) begin
            k_eff = K_W'(1);
        end else if (32'(r_taps_in_use) > 32'(MAX_TAPS)) begin
            k_eff = K_W'(MAX_TAPS);
        end else begin
            k_eff = K_W'(r_taps_in_use);
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The pipeline moves as a whole unless the skid register
    // is occupied; the output register alone never holds it up.
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic r_clr_busy;
    logic [CH_AW-1:0] r_clr_addr;
    logic adv;
    logic accept;

    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid || r_clr_busy;
    assign accept  = i_valid && !o_stall;

    // Clearing pass over the history stores after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the transferred item, alongside the store read data.
    // ------------------------------------------------------------------
    logic                          r_s1_valid;
    logic [dcc_pkg::REQ_W-1:0]     r_s1_type;
    logic [dcc_pkg::CH_W-1:0]      r_s1_ch;
    logic [dcc_pkg::TAP_W-1:0]     r_s1_tap;
    logic signed [SW-1:0]          r_s1_value;
    logic                          r_s1_start;
    logic [CH_AW-1:0]              rd_addr;
    logic [CH_AW-1:0]              s1_addr;

    assign rd_addr = CH_AW'(i_channel);
    assign s1_addr = CH_AW'(r_s1_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_type  <= i_req_type;
            r_s1_ch    <= i_channel;
            r_s1_tap   <= i_tap;
            r_s1_value <= i_value;
            r_s1_start <= i_sequence_start;
        end
    end

    // Decode of the item leaving stage 1. All store writes happen as it leaves.
    logic s1_fire;
    logic s1_ch_ok;
    logic s1_sample;
    logic s1_hzero;

    assign s1_fire   = r_s1_valid && adv;
    assign s1_ch_ok  = 32'(r_s1_ch) < 32'(NUM_CHANNELS);
    assign s1_sample = (r_s1_type == dcc_pkg::REQ_SAMPLE) && s1_ch_ok
                    && ({1'b0, r_s1_ch} < r_channels_in_use);
    assign s1_hzero  = r_s1_start && !r_use_tail;

    // Bias store, with a bypass for the write on the same edge as a read.
    logic signed [SW-1:0] r_bmem [NUM_CHANNELS];
    logic signed [SW-1:0] r_b_rd;
    logic                 r_bbyp_v;
    logic [CH_AW-1:0]     r_bbyp_addr;
    logic signed [SW-1:0] r_bbyp_data;
    logic                 b_we;
    logic signed [SW-1:0] b_eff;

    assign b_we = s1_fire && (r_s1_type == dcc_pkg::REQ_BIAS) && s1_ch_ok;

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[s1_addr] <= r_s1_value;
        end
        if (adv) begin
            r_b_rd <= r_bmem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bbyp_v <= 1'b0;
        end else if (b_we) begin
            r_bbyp_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bbyp_addr <= s1_addr;
            r_bbyp_data <= r_s1_value;
        end
    end

    assign b_eff = (r_bbyp_v && (r_bbyp_addr == s1_addr)) ? r_bbyp_data : r_b_rd;

    // ------------------------------------------------------------------
    // Stages 2 and 3 of the sideband; the bias enters the chain as bias*4096.
    // ------------------------------------------------------------------
    logic                     r_s2_valid;
    logic [dcc_pkg::CH_W-1:0] r_s2_ch;
    logic signed [SW-1:0]     r_s2_bias;
    logic                     r_s3_valid;
    logic [dcc_pkg::CH_W-1:0] r_s3_ch;
    logic [AW-1:0]            r_s3_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && s1_sample;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_bias <= b_eff;
            r_s3_ch   <= r_s2_ch;
            r_s3_psum <= {{(AW - SW - dcc_pkg::FRAC_W){r_s2_bias[SW-1]}}, r_s2_bias,
                          {dcc_pkg::FRAC_W{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Row of tap cells. Cell j holds weight tap j and history slot j; the
    // history shifts one cell to the right on every sample on a channel in use.
    // ------------------------------------------------------------------
    dcc_pkg::t_link       w_link [MAX_TAPS+1];
    logic signed [SW-1:0] w_hist [MAX_TAPS];

    assign w_link[0] = '{valid: r_s3_valid, channel: r_s3_ch, psum: r_s3_psum};

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        dcc_pkg::t_cell_ctl   ctl;
        logic signed [SW-1:0] shift_in;
        logic signed [SW-1:0] h_wdata;
        logic [CH_AW-1:0]     h_waddr;
        logic signed [SW-1:0] x_sel;

        if (j == 0) begin : g_head
            assign shift_in = r_s1_value;
        end else begin : g_body
            assign shift_in = w_hist[j-1];
        end

        assign ctl.w_we   = s1_fire && (r_s1_type == dcc_pkg::REQ_WEIGHT) && s1_ch_ok
                         && (32'(r_s1_tap) == j);
        assign ctl.h_we   = r_clr_busy
                         || (s1_fire && (s1_sample
                             || ((r_s1_type == dcc_pkg::REQ_HISTORY) && s1_ch_ok
                                 && (32'(r_s1_tap) == j))));
        assign ctl.h_zero = s1_hzero;
        assign ctl.active = 32'(k_eff) > j;

        assign h_waddr = r_clr_busy ? r_clr_addr : s1_addr;

        always_comb begin
            if (r_clr_busy) begin
                h_wdata = '0;
            end else if (r_s1_type == dcc_pkg::REQ_SAMPLE) begin
                h_wdata = shift_in;
            end else begin
                h_wdata = r_s1_value;
            end
        end

        // Tap j multiplies the sample K-1-j steps back.
        always_comb begin
            x_sel = '0;
            if (32'(k_eff) == j + 1) begin
                x_sel = r_s1_value;
            end
            for (int s = 0; s < MAX_TAPS - 1; s++) begin
                if (32'(k_eff) == s + j + 2) begin
                    x_sel = w_hist[s];
                end
            end
        end

        dcc_tap_cell #(
            .NUM_CHANNELS (NUM_CHANNELS),
            .MAX_TAPS     (MAX_TAPS),
            .IDX          (j)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_rd_addr (rd_addr),
            .i_s1_addr (s1_addr),
            .i_ctl     (ctl),
            .i_w_wdata (r_s1_value),
            .i_h_waddr (h_waddr),
            .i_h_wdata (h_wdata),
            .i_x       (x_sel),
            .o_hist    (w_hist[j]),
            .i_link    (w_link[j]),
            .o_link    (w_link[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Saturation and output stage with skid register.
    // ------------------------------------------------------------------
    dcc_pkg::t_link                  last;
    logic signed [dcc_pkg::OUT_W-1:0] sat_val;
    logic                            in_range;

    assign last     = w_link[MAX_TAPS];
    assign in_range = (last.psum[AW-1:dcc_pkg::OUT_W-1] == '0)
                   || (last.psum[AW-1:dcc_pkg::OUT_W-1] == '1);

    always_comb begin
        if (in_range) begin
            sat_val = last.psum[dcc_pkg::OUT_W-1:0];
        end else if (last.psum[AW-1]) begin
            sat_val = {1'b1, {(dcc_pkg::OUT_W - 1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(dcc_pkg::OUT_W - 1){1'b1}}};
        end
    end

    logic                             r_out_valid;
    logic signed [dcc_pkg::OUT_W-1:0] r_out_val;
    logic [dcc_pkg::CH_W-1:0]         r_out_ch;
    logic signed [dcc_pkg::OUT_W-1:0] r_skid_val;
    logic [dcc_pkg::CH_W-1:0]         r_skid_ch;
    logic                             pipe_out;
    logic                             out_load_new;
    logic                             out_load_skid;
    logic                             skid_load;

    assign pipe_out      = adv && last.valid;
    assign out_load_new  = pipe_out && (!r_out_valid || !i_stall);
    assign skid_load     = pipe_out && r_out_valid && i_stall;
    assign out_load_skid = r_skid_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_load_new || out_load_skid) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (skid_load) begin
                r_skid_valid <= 1'b1;
            end else if (out_load_skid) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_new) begin
            r_out_val <= sat_val;
            r_out_ch  <= last.channel;
        end else if (out_load_skid) begin
            r_out_val <= r_skid_val;
            r_out_ch  <= r_skid_ch;
        end
        if (skid_load) begin
            r_skid_val <= sat_val;
            r_skid_ch  <= last.channel;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_filtered_value = r_out_val;
    assign o_out_channel    = r_out_ch;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `DCC_ASSERT_IMM(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid register full while output register empty")
    `DCC_ASSERT_NXT(a_no_item_in_clear, i_clk, i_rst_n, r_clr_busy, !r_s1_valid, "item entered the pipeline during the clearing pass")
    `DCC_ASSERT_NXT(a_chain_frozen, i_clk, i_rst_n, r_skid_valid, $stable(w_link[MAX_TAPS].valid), "cell chain moved while the skid register was full")
    `DCC_ASSERT_IMM(a_clear_complete, i_clk, i_rst_n, $fell(r_clr_busy), $past(r_clr_addr) == CLR_LAST, "clearing pass ended before the last channel")

endmodule

`default_nettype wire

>>> sv/dcc_tap_cell.sv
// One tap of the depthwise causal filter: weight and history stores, multiplier,
// product delay and partial-sum stage. Depends on dcc_pkg.
`default_nettype none

module dcc_tap_cell #(
    parameter int NUM_CHANNELS = dcc_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_TAPS     = dcc_pkg::MAX_TAPS_DEF,
    parameter int IDX          = 0,
    localparam int CH_AW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_adv,
    input  wire logic [CH_AW-1:0]                    i_rd_addr,
    input  wire logic [CH_AW-1:0]                    i_s1_addr,
    input  wire dcc_pkg::t_cell_ctl                  i_ctl,
    input  wire logic signed [dcc_pkg::SAMPLE_W-1:0] i_w_wdata,
    input  wire logic [CH_AW-1:0]                    i_h_waddr,
    input  wire logic signed [dcc_pkg::SAMPLE_W-1:0] i_h_wdata,
    input  wire logic signed [dcc_pkg::SAMPLE_W-1:0] i_x,
    output logic signed [dcc_pkg::SAMPLE_W-1:0]      o_hist,
    input  wire dcc_pkg::t_link                      i_link,
    output dcc_pkg::t_link                           o_link
);

    localparam bit HAS_HIST = (IDX < MAX_TAPS - 1);

    // Weight store for this tap, with a one-entry bypass for the write that
    // lands on the same edge as a read.
    logic signed [dcc_pkg::SAMPLE_W-1:0] r_wmem [NUM_CHANNELS];
    logic signed [dcc_pkg::SAMPLE_W-1:0] r_w_rd;
    logic                                r_wbyp_v;
    logic [CH_AW-1:0]                    r_wbyp_addr;
    logic signed [dcc_pkg::SAMPLE_W-1:0] r_wbyp_data;
    logic signed [dcc_pkg::SAMPLE_W-1:0] w_eff;

    logic signed [dcc_pkg::SAMPLE_W-1:0] r_x;
    logic signed [dcc_pkg::SAMPLE_W-1:0] r_w;
    logic signed [dcc_pkg::PROD_W-1:0]   r_prod;
    logic signed [dcc_pkg::PROD_W-1:0]   prod_d;

    logic                                r_lk_valid;
    logic [dcc_pkg::CH_W-1:0]            r_lk_ch;
    logic [dcc_pkg::ACC_W-1:0]           r_lk_psum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.w_we) begin
            r_wmem[i_s1_addr] <= i_w_wdata;
        end
        if (i_adv) begin
            r_w_rd <= r_wmem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbyp_v <= 1'b0;
        end else if (i_ctl.w_we) begin
            r_wbyp_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.w_we) begin
            r_wbyp_addr <= i_s1_addr;
            r_wbyp_data <= i_w_wdata;
        end
    end

    assign w_eff = (r_wbyp_v && (r_wbyp_addr == i_s1_addr)) ? r_wbyp_data : r_w_rd;

    // History slot IDX, i.e. the sample IDX+1 steps back.
    if (HAS_HIST) begin : g_hist
        logic signed [dcc_pkg::SAMPLE_W-1:0] r_hmem [NUM_CHANNELS];
        logic signed [dcc_pkg::SAMPLE_W-1:0] r_h_rd;
        logic                                r_hbyp_v;
        logic [CH_AW-1:0]                    r_hbyp_addr;
        logic signed [dcc_pkg::SAMPLE_W-1:0] r_hbyp_data;

        always_ff @(posedge i_clk) begin
            if (i_ctl.h_we) begin
                r_hmem[i_h_waddr] <= i_h_wdata;
            end
            if (i_adv) begin
                r_h_rd <= r_hmem[i_rd_addr];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hbyp_v <= 1'b0;
            end else if (i_ctl.h_we) begin
                r_hbyp_v <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.h_we) begin
                r_hbyp_addr <= i_h_waddr;
                r_hbyp_data <= i_h_wdata;
            end
        end

        always_comb begin
            if (i_ctl.h_zero) begin
                o_hist = '0;
            end else if (r_hbyp_v && (r_hbyp_addr == i_s1_addr)) begin
                o_hist = r_hbyp_data;
            end else begin
                o_hist = r_h_rd;
            end
        end
    end else begin : g_no_hist
        assign o_hist = '0;
    end

    // Operand and product stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x    <= i_x;
            r_w    <= i_ctl.active ? w_eff : '0;
            r_prod <= r_x * r_w;
        end
    end

    // Delay the product so it meets the partial sum arriving from the left.
    if (IDX == 0) begin : g_no_dly
        assign prod_d = r_prod;
    end else begin : g_dly
        logic signed [dcc_pkg::PROD_W-1:0] r_dly [IDX];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dly[0] <= r_prod;
                for (int i = 1; i < IDX; i++) begin
                    r_dly[i] <= r_dly[i-1];
                end
            end
        end

        assign prod_d = r_dly[IDX-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_valid <= 1'b0;
        end else if (i_adv) begin
            r_lk_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lk_ch   <= i_link.channel;
            r_lk_psum <= i_link.psum
                       + {{(dcc_pkg::ACC_W - dcc_pkg::PROD_W){prod_d[dcc_pkg::PROD_W-1]}},
                          prod_d};
        end
    end

    assign o_link = '{valid: r_lk_valid, channel: r_lk_ch, psum: r_lk_psum};

endmodule

`default_nettype wire

>>> tb/sv/dcc_result_checker.sv
// Result checker for the depthwise causal convolution unit: predicts each filtered result.
// It watches the configuration port and both channels, and compares each output transfer.
// Depends on dcc_pkg only.
`default_nettype none

module dcc_result_checker #(
    parameter int NUM_CHANNELS = dcc_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_TAPS     = dcc_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic                                i_pready,
    input  wire logic [dcc_pkg::PADDR_W-1:0]         i_paddr,
    input  wire logic [dcc_pkg::APB_DW-1:0]          i_pwdata,
    input  wire logic [dcc_pkg::APB_DW-1:0]          i_prdata,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic [dcc_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic [dcc_pkg::CH_W-1:0]            i_channel,
    input  wire logic [dcc_pkg::TAP_W-1:0]           i_tap,
    input  wire logic signed [dcc_pkg::SAMPLE_W-1:0] i_value,
    input  wire logic                                i_sequence_start,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic signed [dcc_pkg::OUT_W-1:0]    i_filtered_value,
    input  wire logic [dcc_pkg::CH_W-1:0]            i_out_channel,
    output int                                       o_mismatches,
    output int                                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dcc_pkg::*;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [CH_W-1:0]         channel;
    } filt_result_t;

    filt_result_t awaited_results[$];

    logic signed [SAMPLE_W-1:0] coeff_store  [NUM_CHANNELS][MAX_TAPS];
    logic signed [SAMPLE_W-1:0] bias_store   [NUM_CHANNELS];
    // Slot s holds the sample s+1 steps back; the last slot is spare.
    logic signed [SAMPLE_W-1:0] past_samples [NUM_CHANNELS][MAX_TAPS];

    logic [CIU_W-1:0] active_channels;
    logic [TIU_W-1:0] tap_count;
    logic             keep_tail;

    function automatic logic signed [OUT_W-1:0] filter_sample(input int ch,
                                                              input logic signed [SAMPLE_W-1:0] x_now);
        int                         k;
        int                         j;
        longint                     acc;
        logic signed [SAMPLE_W-1:0] x;
        k = (tap_count == 0) ? 1 : ((int'(tap_count) > MAX_TAPS) ? MAX_TAPS : int'(tap_count));
        acc = longint'(bias_store[ch]) * 4096;
        for (j = 0; j < k; j++) begin
            x = (k - 1 - j == 0) ? x_now : past_samples[ch][k - 2 - j];
            acc += longint'(coeff_store[ch][j]) * longint'(x);
        end
        if (acc > SUM_MAX) begin
            acc = SUM_MAX;
        end else if (acc < SUM_MIN) begin
            acc = SUM_MIN;
        end
        return acc[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        o_mismatches = o_mismatches + 1;
        if (o_mismatches <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        filt_result_t want;
        int           ch;
        int           s;
        if (!i_rst_n) begin
            for (ch = 0; ch < NUM_CHANNELS; ch++) begin
                bias_store[ch] = '0;
                for (s = 0; s < MAX_TAPS; s++) begin
                    coeff_store[ch][s]  = '0;
                    past_samples[ch][s] = '0;
                end
            end
            active_channels = CIU_RESET;
            tap_count       = TIU_RESET;
            keep_tail       = 1'b0;
            awaited_results.delete();
            o_mismatches  = 0;
            o_outstanding = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[PADDR_W-1:2])
                        REG_CHANNELS: active_channels = i_pwdata[CIU_W-1:0];
                        REG_TAPS:     tap_count       = i_pwdata[TIU_W-1:0];
                        REG_TAIL:     keep_tail       = i_pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (i_paddr[PADDR_W-1:2])
                        REG_CHANNELS: begin
                            if (i_prdata[CIU_W-1:0] !== active_channels) begin
                                report_mismatch($sformatf("channel count read %0d, expected %0d",
                                                          i_prdata[CIU_W-1:0], active_channels));
                            end
                        end
                        REG_TAPS: begin
                            if (i_prdata[TIU_W-1:0] !== tap_count) begin
                                report_mismatch($sformatf("tap count read %0d, expected %0d",
                                                          i_prdata[TIU_W-1:0], tap_count));
                            end
                        end
                        REG_TAIL: begin
                            if (i_prdata[0] !== keep_tail) begin
                                report_mismatch($sformatf("tail mode read %0b, expected %0b",
                                                          i_prdata[0], keep_tail));
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (i_in_valid && !i_in_stall) begin
                ch = int'(i_channel);
                if (ch < NUM_CHANNELS) begin
                    case (i_req_type)
                        REQ_WEIGHT: begin
                            if (int'(i_tap) < MAX_TAPS) begin
                                coeff_store[ch][i_tap] = i_value;
                            end
                        end
                        REQ_BIAS: begin
                            bias_store[ch] = i_value;
                        end
                        REQ_HISTORY: begin
                            if (int'(i_tap) < MAX_TAPS - 1) begin
                                past_samples[ch][i_tap] = i_value;
                            end
                        end
                        REQ_SAMPLE: begin
                            if (ch < int'(active_channels)) begin
                                if (i_sequence_start && !keep_tail) begin
                                    for (s = 0; s < MAX_TAPS; s++) begin
                                        past_samples[ch][s] = '0;
                                    end
                                end
                                want.value   = filter_sample(ch, i_value);
                                want.channel = i_channel;
                                for (s = MAX_TAPS - 2; s > 0; s--) begin
                                    past_samples[ch][s] = past_samples[ch][s - 1];
                                end
                                if (MAX_TAPS > 1) begin
                                    past_samples[ch][0] = i_value;
                                end
                                awaited_results.push_back(want);
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: ch %0d value %0d",
                                              i_out_channel, i_filtered_value));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_filtered_value !== want.value || i_out_channel !== want.channel) begin
                        report_mismatch($sformatf(
                            "result differs: expected ch %0d value %0d, got ch %0d value %0d",
                            want.channel, want.value, i_out_channel, i_filtered_value));
                    end
                end
            end
            o_outstanding = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_depthwise_causal_conv1d_unit.sv
// Top of the testbench for depthwise_causal_conv1d_unit: clock, reset, stimulus and verdict.
// Depends on dcc_pkg, the unit itself and dcc_result_checker, which checks results and register reads.
`default_nettype none

module tb_depthwise_causal_conv1d_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dcc_pkg::*;

    // Cycles with no transfer anywhere before the run is declared hung. The longest
    // legitimate quiet spell is the clearing pass after reset or the long receiver
    // hold-off.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed for the pipeline to empty once the last result has been seen.
    localparam int DRAIN_CYCLES   = MAX_TAPS_DEF + 6;
    // Length of the single long receiver hold-off, and when it happens.
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AFTER  = 150;

    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 16'sh7FFF;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [PADDR_W-1:0]           paddr;
    logic [APB_DW-1:0]            pwdata;
    logic [APB_DW-1:0]            prdata;
    logic                         pready;
    logic                         i_valid;
    logic                         o_stall;
    logic [REQ_W-1:0]             i_req_type;
    logic [CH_W-1:0]              i_channel;
    logic [TAP_W-1:0]             i_tap;
    logic signed [SAMPLE_W-1:0]   i_value;
    logic                         i_sequence_start;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [OUT_W-1:0]      o_filtered_value;
    logic [CH_W-1:0]              o_out_channel;

    int  mismatches;
    int  outstanding;
    int  quiet_cycles = 0;
    int  results_taken = 0;
    bit  idle_on = 1'b1;
    int  cur_channels = 64;
    bit  cur_tail = 1'b0;

    depthwise_causal_conv1d_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_channel        (i_channel),
        .i_tap            (i_tap),
        .i_value          (i_value),
        .i_sequence_start (i_sequence_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_out_channel    (o_out_channel)
    );

    dcc_result_checker result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_req_type       (i_req_type),
        .i_channel        (i_channel),
        .i_tap            (i_tap),
        .i_value          (i_value),
        .i_sequence_start (i_sequence_start),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_filtered_value (o_filtered_value),
        .i_out_channel    (o_out_channel),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    // A 10 ns clock: five nanoseconds high, five low.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The watchdog counts cycles in which no transfer happens on either channel and
    // no register access completes. Reaching the limit means the block has hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("depthwise_causal_conv1d_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver. For every result it draws a number of cycles to hold stall high before
    // lowering it and waiting for the transfer. Once, after a fair number of results,
    // it holds off for a long stretch so that the pipeline and its skid register fill
    // and the block has to stall its input while the sender keeps offering items.
    initial begin
        bit pressure_done;
        int hold;
        pressure_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && results_taken >= HOLD_OFF_AFTER) begin
                pressure_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            hold = idle_on ? $urandom_range(0, 5) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            results_taken++;
        end
    end

    // Values lean towards the extremes of the Q4.12 range now and then, so that sums
    // saturate from time to time; otherwise every bit pattern is fair game.
    function automatic logic signed [SAMPLE_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly a channel that is currently in use, sometimes any channel at all so that
    // samples on idle channels get dropped.
    function automatic int pick_channel();
        int in_use;
        in_use = (cur_channels > 64) ? 64 : cur_channels;
        if (in_use == 0 || $urandom_range(0, 99) < 15) begin
            return $urandom_range(0, 63);
        end
        return $urandom_range(0, in_use - 1);
    endfunction

    // Offers one item on the input channel. Called at a falling edge, returns at the
    // falling edge after the transfer with valid still high, so that back-to-back
    // items need no gap. A drawn gap lowers valid first.
    task automatic send_item(input logic [REQ_W-1:0] kind, input int ch, input int slot,
                             input logic signed [SAMPLE_W-1:0] val, input bit start);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type       <= kind;
        i_channel        <= CH_W'(ch);
        i_tap            <= TAP_W'(slot);
        i_value          <= val;
        i_sequence_start <= start;
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        @(negedge i_clk);
    endtask

    // One register access: setup cycle, access cycle, then an idle cycle so that the
    // next access starts at a fresh falling edge.
    task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes a register with noise in the unused upper bits, then reads it back; the
    // checker compares the read data.
    task automatic set_register(input logic [1:0] idx, input int val, input int width);
        logic [APB_DW-1:0] keep_mask;
        keep_mask = (APB_DW'(1) << width) - 1;
        reg_access(1'b1, idx, (APB_DW'($urandom) & ~keep_mask) | (APB_DW'(val) & keep_mask));
        reg_access(1'b0, idx, '0);
    endtask

    // Starts a new phase: stops offering items, lets every awaited result arrive and
    // the pipeline empty of loads, then writes all three registers.
    task automatic set_phase(input int chans, input int taps, input bit tail);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        set_register(REG_CHANNELS, chans, CIU_W);
        set_register(REG_TAPS, taps, TIU_W);
        set_register(REG_TAIL, tail, 1);
        cur_channels = chans;
        cur_tail     = tail;
    endtask

    // Random traffic. Half the time a well-formed sequence: optional history loads
    // (the tail of the previous chunk), a sequence-start sample, then a run of
    // continuation samples with other channels' samples interleaved. The rest are
    // coefficient and bias rewrites, stray continuation samples and pure noise,
    // including history loads to the slot that does not exist.
    task automatic run_random(input int budget);
        int sent;
        int ch;
        int n;
        int len;
        int i;
        int pick;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            ch   = pick_channel();
            if (pick < 50) begin
                n = (cur_tail || $urandom_range(0, 1)) ? $urandom_range(0, 3) : 0;
                for (i = 0; i < n; i++) begin
                    send_item(REQ_HISTORY, ch,
                              ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2),
                              rand_value(), $urandom_range(0, 1));
                end
                send_item(REQ_SAMPLE, ch, $urandom_range(0, 3), rand_value(), 1'b1);
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_item(REQ_SAMPLE, pick_channel(), $urandom_range(0, 3),
                                  rand_value(), $urandom_range(0, 7) == 0);
                        sent++;
                    end
                    send_item(REQ_SAMPLE, ch, $urandom_range(0, 3), rand_value(), 1'b0);
                end
                sent += n + 1 + len;
            end else if (pick < 70) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(REQ_BIAS, ch, $urandom_range(0, 3), rand_value(),
                              $urandom_range(0, 1));
                end else begin
                    send_item(REQ_WEIGHT, ch, $urandom_range(0, 3), rand_value(),
                              $urandom_range(0, 1));
                end
                sent++;
            end else if (pick < 85) begin
                send_item(REQ_SAMPLE, ch, $urandom_range(0, 3), rand_value(), 1'b0);
                sent++;
            end else begin
                send_item(REQ_TYPE_ANY(), $urandom_range(0, 63), $urandom_range(0, 3),
                          SAMPLE_W'($urandom), $urandom_range(0, 1));
                sent++;
            end
        end
    endtask

    // Any of the four request kinds, for noise items.
    function automatic logic [REQ_W-1:0] REQ_TYPE_ANY();
        case ($urandom_range(0, 3))
            0:       return REQ_WEIGHT;
            1:       return REQ_BIAS;
            2:       return REQ_HISTORY;
            default: return REQ_SAMPLE;
        endcase
    endfunction

    initial begin
        int ch;
        int t;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_valid          = 1'b0;
        i_req_type       = REQ_WEIGHT;
        i_channel        = '0;
        i_tap            = '0;
        i_value          = '0;
        i_sequence_start = 1'b0;

        // Synchronous reset, released at a falling edge. The block then runs its
        // clearing pass with o_stall high; the first item simply waits for its
        // transfer.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Weights and bias have no value until loaded, so every channel gets a full
        // set before any sample is sent. Random traffic rewrites them but never
        // leaves one unloaded.
        for (ch = 0; ch < 64; ch++) begin
            for (t = 0; t < 4; t++) begin
                send_item(REQ_WEIGHT, ch, t, rand_value(), 1'b0);
            end
            send_item(REQ_BIAS, ch, 0, rand_value(), 1'b0);
        end

        // Directed part, at the reset settings. Channel 0 gets the most negative
        // weights everywhere and history full of the most negative sample, so the
        // sum overflows upwards and must saturate at the top of the range. The
        // sequence-start flag on loads must be ignored, as must a history load to
        // the slot beyond the last.
        for (t = 0; t < 4; t++) begin
            send_item(REQ_WEIGHT, 0, t, Q_MIN, 1'b0);
        end
        send_item(REQ_BIAS, 0, 0, Q_MAX, 1'b1);
        for (t = 0; t < 3; t++) begin
            send_item(REQ_HISTORY, 0, t, Q_MIN, 1'b1);
        end
        send_item(REQ_HISTORY, 0, 3, Q_MAX, 1'b0);
        send_item(REQ_SAMPLE, 0, 0, Q_MIN, 1'b0);
        // A sequence start outside tail mode wipes the history first.
        send_item(REQ_SAMPLE, 0, 3, Q_MAX, 1'b1);
        // Channel 1 saturates at the bottom once its history fills with the largest
        // positive sample against the most negative weights and bias.
        for (t = 0; t < 4; t++) begin
            send_item(REQ_WEIGHT, 1, t, Q_MIN, 1'b0);
        end
        send_item(REQ_BIAS, 1, 0, Q_MIN, 1'b0);
        send_item(REQ_SAMPLE, 1, 0, Q_MAX, 1'b1);
        for (t = 0; t < 3; t++) begin
            send_item(REQ_SAMPLE, 1, t, Q_MAX, 1'b0);
        end
        // The top channel, on its own.
        send_item(REQ_SAMPLE, 63, 2, '0, 1'b0);

        // Random phases, each with its own register setting. They cover a single
        // channel and a single tap, a channel count beyond the channels present,
        // no channels at all, tap counts of zero and above the maximum, and tail
        // mode both ways. One phase runs with no idling on either side.
        set_phase(64, 4, 1'b1);
        run_random(150);
        set_phase(1, 1, 1'b0);
        run_random(100);
        idle_on = 1'b0;
        set_phase(127, 7, 1'b1);
        run_random(150);
        idle_on = 1'b1;
        set_phase(0, 0, 1'b0);
        run_random(30);
        set_phase(37, 2, 1'b1);
        run_random(140);
        set_phase(64, 3, 1'b0);
        run_random(140);
        set_phase(20, 5, 1'b1);
        run_random(140);
        set_phase(64, 6, 1'b0);
        run_random(90);

        // All stimulus has been transferred: wait for the last results, then give the
        // pipeline time to show any stray result before the verdict.
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES + 10) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("depthwise_causal_conv1d_unit: match");
        end else begin
            $display("depthwise_causal_conv1d_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
